@@ hdl/stereo_fir_decimator_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the stereo FIR decimator core
// Immediate-implication and next-cycle-implication forms, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef STEREO_FIR_DECIMATOR_CORE_ASSERT_SVH
`define STEREO_FIR_DECIMATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSD_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FSD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hdl/fsd_pkg.sv @@
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared widths, codes, state encoding and structs of the stereo FIR decimator.
// ----------------------------------------------------------------------------
package fsd_pkg;

    localparam int DATA_W       = 24;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int IDX_W        = 8;
    localparam int FACTOR_W     = 5;
    localparam int TAPS_W       = 9;
    localparam int PHASE_W      = 4;
    localparam int MAX_FACTOR   = 16;
    localparam int MAX_TAPS_DEF = 256;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    localparam logic [FACTOR_W-1:0] RST_FACTOR = 5'd2;
    localparam logic [TAPS_W-1:0]   RST_TAPS   = 9'd256;

    localparam int ROUND_HALF = 1 << 22;
    localparam int ROUND_SHIFT = 23;
    localparam int SAT_MAX    = 8388607;
    localparam int SAT_MIN    = -8388608;

    // Request types carried in the req_type field.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEFF  = 1'b1;

    // Register select, taken from the word address bit.
    localparam logic REG_FACTOR = 1'b0;
    localparam logic REG_TAPS   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_OUTPUT
    } t_state;

    typedef struct packed {
        logic [FACTOR_W-1:0] factor;
        logic [TAPS_W-1:0]   tap_count;
    } t_cfg;

    typedef struct packed {
        logic clr;
        logic rd_v;
        logic rnd;
    } t_mac_ctl;

    typedef struct packed {
        logic [DATA_W-1:0] left_out;
        logic [DATA_W-1:0] right_out;
        logic              clipped;
    } t_result;

endpackage

@@ hdl/fsd_if.sv @@
// ----------------------------------------------------------------------------
// fsd_in_if / fsd_out_if
// Valid/ready stream channels for sample and coefficient requests and results.
// ----------------------------------------------------------------------------
interface fsd_in_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic signed [fsd_pkg::DATA_W-1:0]   left_sample;
    logic signed [fsd_pkg::DATA_W-1:0]   right_sample;
    logic        [fsd_pkg::IDX_W-1:0]    coeff_index;
    logic signed [fsd_pkg::DATA_W-1:0]   coeff_value;

    modport source (
        output valid, req_type, left_sample, right_sample, coeff_index, coeff_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, left_sample, right_sample, coeff_index, coeff_value,
        output ready
    );
endinterface

interface fsd_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [fsd_pkg::DATA_W-1:0] left_out;
    logic signed [fsd_pkg::DATA_W-1:0] right_out;
    logic                              clipped;

    modport source (
        output valid, left_out, right_out, clipped,
        input  ready
    );
    modport sink (
        input  valid, left_out, right_out, clipped,
        output ready
    );
endinterface

@@ hdl/fsd_ram.sv @@
// ----------------------------------------------------------------------------
// fsd_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module fsd_ram #(
    parameter int W     = fsd_pkg::DATA_W,
    parameter int DEPTH = fsd_pkg::MAX_TAPS_DEF,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/fsd_regs.sv @@
// ----------------------------------------------------------------------------
// fsd_regs
// APB-style configuration registers: decimation factor and tap count.
// ----------------------------------------------------------------------------
module fsd_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fsd_pkg::APB_AW-1:0]    paddr,
    input  logic [fsd_pkg::APB_DW-1:0]    pwdata,
    output logic [fsd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output fsd_pkg::t_cfg                 o_cfg
);

    fsd_pkg::t_cfg r_cfg;
    logic          w_wr;

    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.factor    <= fsd_pkg::RST_FACTOR;
            r_cfg.tap_count <= fsd_pkg::RST_TAPS;
        end else if (w_wr) begin
            case (paddr[2])
                fsd_pkg::REG_FACTOR: r_cfg.factor    <= pwdata[fsd_pkg::FACTOR_W-1:0];
                fsd_pkg::REG_TAPS:   r_cfg.tap_count <= pwdata[fsd_pkg::TAPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            fsd_pkg::REG_FACTOR: prdata = fsd_pkg::APB_DW'(r_cfg.factor);
            fsd_pkg::REG_TAPS:   prdata = fsd_pkg::APB_DW'(r_cfg.tap_count);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/fsd_mac.sv @@
// ----------------------------------------------------------------------------
// fsd_mac
// Two-channel multiply-accumulate with rounding and saturation to Q1.23.
// ----------------------------------------------------------------------------
module fsd_mac #(
    parameter int ACC_W = fsd_pkg::PROD_W + 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fsd_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [fsd_pkg::DATA_W-1:0] i_left,
    input  logic signed [fsd_pkg::DATA_W-1:0] i_right,
    input  logic signed [fsd_pkg::DATA_W-1:0] i_tap,
    output logic                              o_busy,
    output fsd_pkg::t_result                  o_res
);

    localparam int RW = ACC_W + 1 - fsd_pkg::ROUND_SHIFT;
    localparam logic signed [RW-1:0] L_MAX = RW'(fsd_pkg::SAT_MAX);
    localparam logic signed [RW-1:0] L_MIN = RW'(fsd_pkg::SAT_MIN);

    logic                              r_mul_v;
    logic signed [fsd_pkg::PROD_W-1:0] r_pl;
    logic signed [fsd_pkg::PROD_W-1:0] r_pr;
    logic signed [ACC_W-1:0]           r_acc_l;
    logic signed [ACC_W-1:0]           r_acc_r;
    logic signed [ACC_W:0]             w_sum_l;
    logic signed [ACC_W:0]             w_sum_r;
    logic signed [RW-1:0]              w_sl;
    logic signed [RW-1:0]              w_sr;
    logic                              w_clip_l;
    logic                              w_clip_r;
    fsd_pkg::t_result                  r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
        end else begin
            r_mul_v <= i_ctl.rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pl <= i_left * i_tap;
        r_pr <= i_right * i_tap;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc_l <= '0;
            r_acc_r <= '0;
        end else if (r_mul_v) begin
            r_acc_l <= r_acc_l + ACC_W'(r_pl);
            r_acc_r <= r_acc_r + ACC_W'(r_pr);
        end
    end

    // Round half up: add half an LSB of the output, then floor by the shift.
    assign w_sum_l = {r_acc_l[ACC_W-1], r_acc_l} + (ACC_W+1)'(fsd_pkg::ROUND_HALF);
    assign w_sum_r = {r_acc_r[ACC_W-1], r_acc_r} + (ACC_W+1)'(fsd_pkg::ROUND_HALF);
    assign w_sl    = w_sum_l[ACC_W:fsd_pkg::ROUND_SHIFT];
    assign w_sr    = w_sum_r[ACC_W:fsd_pkg::ROUND_SHIFT];
    assign w_clip_l = (w_sl > L_MAX) || (w_sl < L_MIN);
    assign w_clip_r = (w_sr > L_MAX) || (w_sr < L_MIN);

    always_ff @(posedge i_clk) begin
        if (i_ctl.rnd) begin
            if (w_sl > L_MAX) begin
                r_res.left_out <= L_MAX[fsd_pkg::DATA_W-1:0];
            end else if (w_sl < L_MIN) begin
                r_res.left_out <= L_MIN[fsd_pkg::DATA_W-1:0];
            end else begin
                r_res.left_out <= w_sl[fsd_pkg::DATA_W-1:0];
            end
            if (w_sr > L_MAX) begin
                r_res.right_out <= L_MAX[fsd_pkg::DATA_W-1:0];
            end else if (w_sr < L_MIN) begin
                r_res.right_out <= L_MIN[fsd_pkg::DATA_W-1:0];
            end else begin
                r_res.right_out <= w_sr[fsd_pkg::DATA_W-1:0];
            end
            r_res.clipped <= w_clip_l || w_clip_r;
        end
    end

    assign o_busy = r_mul_v;
    assign o_res  = r_res;

endmodule

@@ hdl/stereo_fir_decimator_core.sv @@
// ----------------------------------------------------------------------------
// stereo_fir_decimator_core
// A sample that opens a group runs one multiply-accumulate per effective tap, then
// the MAC pipeline drains, the sums are rounded and the result register is loaded.
// The delay and tap memories each have a single read port, and no new request is
// accepted until that result is loaded; other samples and coefficient writes are
// taken in the idle state, which they do not leave.
// After reset a clearing pass zeroes every delay memory address first.
// ----------------------------------------------------------------------------
`include "stereo_fir_decimator_core_assert.svh"

module stereo_fir_decimator_core #(
    parameter int MAX_TAPS = fsd_pkg::MAX_TAPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fsd_in_if.sink                        i_sample,
    fsd_out_if.source                     o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fsd_pkg::APB_AW-1:0]    paddr,
    input  logic [fsd_pkg::APB_DW-1:0]    pwdata,
    output logic [fsd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW    = $clog2(MAX_TAPS + 1);
    localparam int ACC_W = fsd_pkg::PROD_W + AW;
    localparam int DW    = fsd_pkg::DATA_W;

    fsd_pkg::t_cfg     w_cfg;
    fsd_pkg::t_state   r_state, n_state;
    fsd_pkg::t_mac_ctl w_mac_ctl;
    fsd_pkg::t_result  w_mac_res;
    fsd_pkg::t_result  r_out;

    logic [AW-1:0]                  r_cnt, n_cnt;
    logic [AW-1:0]                  r_wp, n_wp;
    logic [AW-1:0]                  r_rd_ptr, n_rd_ptr;
    logic [fsd_pkg::PHASE_W-1:0]    r_phase, n_phase;
    logic                           r_rd_v;
    logic                           r_out_valid, n_out_valid;
    logic                           w_mac_busy;

    logic [CW-1:0]                  w_n;
    logic [fsd_pkg::FACTOR_W-1:0]   w_l;
    logic [AW-1:0]                  w_wp_eff;
    logic [CW-1:0]                  w_wp_inc;
    logic [fsd_pkg::PHASE_W-1:0]    w_ph_eff;
    logic [fsd_pkg::FACTOR_W-1:0]   w_ph_inc;
    logic                           w_start;
    logic                           w_in_ready;
    logic                           w_in_fire;
    logic                           w_is_sample;
    logic                           w_out_load;

    logic                           w_dly_we;
    logic [AW-1:0]                  w_dly_waddr;
    logic [2*DW-1:0]                w_dly_wdata;
    logic [2*DW-1:0]                w_dly_rdata;
    logic                           w_tap_we;
    logic [DW-1:0]                  w_tap_rdata;

    fsd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Effective tap count and decimation factor, clamped to their legal ranges.
    always_comb begin
        if (w_cfg.tap_count == '0) begin
            w_n = CW'(1);
        end else if (32'(w_cfg.tap_count) > MAX_TAPS) begin
            w_n = CW'(MAX_TAPS);
        end else begin
            w_n = CW'(w_cfg.tap_count);
        end
        if (w_cfg.factor == '0) begin
            w_l = fsd_pkg::FACTOR_W'(1);
        end else if (w_cfg.factor > fsd_pkg::FACTOR_W'(fsd_pkg::MAX_FACTOR)) begin
            w_l = fsd_pkg::FACTOR_W'(fsd_pkg::MAX_FACTOR);
        end else begin
            w_l = w_cfg.factor;
        end
    end

    // A write position or phase left stale by a smaller configuration restarts at zero.
    assign w_wp_eff    = (CW'(r_wp) >= w_n) ? '0 : r_wp;
    assign w_wp_inc    = CW'(w_wp_eff) + CW'(1);
    assign w_ph_eff    = ({1'b0, r_phase} >= w_l) ? '0 : r_phase;
    assign w_ph_inc    = {1'b0, w_ph_eff} + fsd_pkg::FACTOR_W'(1);
    assign w_start     = (w_ph_eff == '0);
    assign w_is_sample = (i_sample.req_type == fsd_pkg::REQ_SAMPLE);
    assign w_in_fire   = i_sample.valid && w_in_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            fsd_pkg::ST_CLEAR: begin
                if (r_cnt == AW'(MAX_TAPS - 1)) begin
                    n_state = fsd_pkg::ST_IDLE;
                end
            end
            fsd_pkg::ST_IDLE: begin
                if (w_in_fire && w_is_sample && w_start) begin
                    n_state = fsd_pkg::ST_MAC;
                end
            end
            fsd_pkg::ST_MAC: begin
                if (CW'(r_cnt) == w_n - CW'(1)) begin
                    n_state = fsd_pkg::ST_DRAIN;
                end
            end
            fsd_pkg::ST_DRAIN: begin
                if (!r_rd_v && !w_mac_busy) begin
                    n_state = fsd_pkg::ST_ROUND;
                end
            end
            fsd_pkg::ST_ROUND: begin
                n_state = fsd_pkg::ST_OUTPUT;
            end
            fsd_pkg::ST_OUTPUT: begin
                if (w_out_load) begin
                    n_state = fsd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fsd_pkg::ST_IDLE;
            end
        endcase
    end

    // State-dependent controls.
    always_comb begin
        w_in_ready    = (r_state == fsd_pkg::ST_IDLE);
        w_out_load    = (r_state == fsd_pkg::ST_OUTPUT) && (!r_out_valid || o_result.ready);
        w_mac_ctl.clr  = w_in_fire && w_is_sample && w_start;
        w_mac_ctl.rd_v = r_rd_v;
        w_mac_ctl.rnd  = (r_state == fsd_pkg::ST_ROUND);
        w_tap_we      = w_in_fire && !w_is_sample &&
                        (32'(i_sample.coeff_index) < MAX_TAPS);
        if (r_state == fsd_pkg::ST_CLEAR) begin
            w_dly_we    = 1'b1;
            w_dly_waddr = r_cnt;
            w_dly_wdata = '0;
        end else begin
            w_dly_we    = w_in_fire && w_is_sample;
            w_dly_waddr = w_wp_eff;
            w_dly_wdata = {i_sample.left_sample, i_sample.right_sample};
        end
    end

    // Counters and pointers.
    always_comb begin
        n_cnt    = r_cnt;
        n_rd_ptr = r_rd_ptr;
        n_wp     = r_wp;
        n_phase  = r_phase;
        case (r_state)
            fsd_pkg::ST_CLEAR: begin
                n_cnt = r_cnt + AW'(1);
            end
            fsd_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (w_in_fire && w_is_sample) begin
                    n_rd_ptr = w_wp_eff;
                    n_wp     = (w_wp_inc >= w_n) ? '0 : AW'(w_wp_inc);
                    n_phase  = (w_ph_inc >= w_l) ? '0 : w_ph_inc[fsd_pkg::PHASE_W-1:0];
                end
            end
            fsd_pkg::ST_MAC: begin
                // Walk back from the newest sample, wrapping at the line length.
                n_cnt    = r_cnt + AW'(1);
                n_rd_ptr = (r_rd_ptr == '0) ? AW'(w_n - CW'(1)) : r_rd_ptr - AW'(1);
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fsd_pkg::ST_CLEAR;
            r_cnt       <= '0;
            r_wp        <= '0;
            r_phase     <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_wp        <= n_wp;
            r_phase     <= n_phase;
            r_rd_v      <= (r_state == fsd_pkg::ST_MAC);
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ptr <= n_rd_ptr;
        if (w_out_load) begin
            r_out <= w_mac_res;
        end
    end

    fsd_ram #(
        .W     (2 * DW),
        .DEPTH (MAX_TAPS),
        .AW    (AW)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (w_dly_we),
        .i_waddr (w_dly_waddr),
        .i_wdata (w_dly_wdata),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_dly_rdata)
    );

    fsd_ram #(
        .W     (DW),
        .DEPTH (MAX_TAPS),
        .AW    (AW)
    ) u_tap_ram (
        .i_clk   (i_clk),
        .i_we    (w_tap_we),
        .i_waddr (AW'(i_sample.coeff_index)),
        .i_wdata (i_sample.coeff_value),
        .i_raddr (r_cnt),
        .o_rdata (w_tap_rdata)
    );

    fsd_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_left  (w_dly_rdata[2*DW-1:DW]),
        .i_right (w_dly_rdata[DW-1:0]),
        .i_tap   (w_tap_rdata),
        .o_busy  (w_mac_busy),
        .o_res   (w_mac_res)
    );

    assign i_sample.ready     = w_in_ready;
    assign o_result.valid     = r_out_valid;
    assign o_result.left_out  = r_out.left_out;
    assign o_result.right_out = r_out.right_out;
    assign o_result.clipped   = r_out.clipped;

    `FSD_ASSERT_NOW(a_mac_cnt_range, i_clk, i_rst_n,
        r_state == fsd_pkg::ST_MAC, CW'(r_cnt) < w_n,
        "tap counter ran past the tap count")
    `FSD_ASSERT_NOW(a_round_drained, i_clk, i_rst_n,
        r_state == fsd_pkg::ST_ROUND, !r_rd_v && !w_mac_busy,
        "rounding started before the MAC pipeline drained")
    `FSD_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n,
        w_in_fire && w_is_sample && w_start, r_state == fsd_pkg::ST_MAC,
        "group start did not launch the convolution")
    `FSD_ASSERT_NEXT(a_result_waits, i_clk, i_rst_n,
        r_state == fsd_pkg::ST_OUTPUT && r_out_valid && !o_result.ready,
        r_state == fsd_pkg::ST_OUTPUT,
        "pending result overwritten a stalled output")

endmodule
